// ===== rtl/tpac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpac_pkg
// Shared widths, codes, state record and direction pick for the actuator
// control block.
// ----------------------------------------------------------------------------
package tpac_pkg;

  localparam int unsigned POS_W   = 3;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned TICK_W  = 10;

  // Position codes (target may also hold the unused codes 6 and 7).
  localparam logic [POS_W-1:0] POS_UNKNOWN   = 3'd0;
  localparam logic [POS_W-1:0] POS_RETRACTED = 3'd1;
  localparam logic [POS_W-1:0] POS_PART_RET  = 3'd2;
  localparam logic [POS_W-1:0] POS_CENTER    = 3'd3;
  localparam logic [POS_W-1:0] POS_PART_EXT  = 3'd4;
  localparam logic [POS_W-1:0] POS_EXTENDED  = 3'd5;

  // Valve commands.
  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

  // Item opcodes.
  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TICK_W-1:0] TICK_MAX           = '1;
  localparam logic [TICK_W-1:0] TRAVEL_TICKS_RESET = 10'd86;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  target;
    logic [DIR_W-1:0]  dir;
    logic              running;
    logic [TICK_W-1:0] elapsed;
  } state_t;

  typedef struct packed {
    logic             move;
    logic [DIR_W-1:0] dir;
  } pick_t;

  // Direction toward the goal; move is low when reached or goal unknown.
  function automatic pick_t pick_dir(input logic [POS_W-1:0] pos,
                                     input logic [POS_W-1:0] target);
    pick_t p;
    p.move = !((pos == target) || (target == POS_UNKNOWN));
    unique case (target)
      POS_RETRACTED: p.dir = DIR_REV;
      POS_PART_RET:  p.dir = (pos == POS_RETRACTED) ? DIR_FWD : DIR_REV;
      POS_CENTER:    p.dir = ((pos == POS_RETRACTED) || (pos == POS_PART_RET))
                             ? DIR_FWD : DIR_REV;
      POS_PART_EXT:  p.dir = (pos == POS_EXTENDED) ? DIR_REV : DIR_FWD;
      POS_EXTENDED:  p.dir = DIR_FWD;
      default:       p.dir = DIR_OFF;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/tpac_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpac_step
// Next-state logic for one item: goal set or travel tick.
// ----------------------------------------------------------------------------
module tpac_step (
  input  tpac_pkg::state_t                 cur,
  input  logic [tpac_pkg::TICK_W-1:0]      travel_ticks,
  input  logic                             op,
  input  logic [tpac_pkg::POS_W-1:0]       new_goal,
  input  logic                             center_line,
  output tpac_pkg::state_t                 nxt
);

  logic [tpac_pkg::TICK_W-1:0] elapsed_inc;
  logic [tpac_pkg::POS_W-1:0]  pos_upd;
  logic                        timed_out;
  tpac_pkg::pick_t             goal_pick;
  tpac_pkg::pick_t             tick_pick;

  // Saturating tick count, then end-of-travel check.
  assign elapsed_inc = (cur.elapsed != tpac_pkg::TICK_MAX)
                       ? cur.elapsed + 1'b1 : cur.elapsed;
  assign timed_out   = (elapsed_inc >= travel_ticks);

  always_comb begin
    pos_upd = cur.pos;
    priority if (!center_line) begin
      pos_upd = tpac_pkg::POS_CENTER;
    end else if (cur.dir == tpac_pkg::DIR_FWD) begin
      priority if (cur.pos == tpac_pkg::POS_RETRACTED) pos_upd = tpac_pkg::POS_PART_RET;
      else if (cur.pos == tpac_pkg::POS_CENTER)        pos_upd = tpac_pkg::POS_PART_EXT;
      else if (timed_out)                              pos_upd = tpac_pkg::POS_EXTENDED;
      else                                             pos_upd = cur.pos;
    end else if (cur.dir == tpac_pkg::DIR_REV) begin
      priority if (cur.pos == tpac_pkg::POS_EXTENDED) pos_upd = tpac_pkg::POS_PART_EXT;
      else if (cur.pos == tpac_pkg::POS_CENTER)       pos_upd = tpac_pkg::POS_PART_RET;
      else if (timed_out)                             pos_upd = tpac_pkg::POS_RETRACTED;
      else                                            pos_upd = cur.pos;
    end else begin
      pos_upd = cur.pos;
    end
  end

  assign goal_pick = tpac_pkg::pick_dir(cur.pos, new_goal);
  assign tick_pick = tpac_pkg::pick_dir(pos_upd, cur.target);

  always_comb begin
    nxt = cur;
    if (op == tpac_pkg::OP_GOAL) begin
      nxt.target  = new_goal;
      nxt.elapsed = '0;
      nxt.running = goal_pick.move;
      if (goal_pick.move) nxt.dir = goal_pick.dir;
    end else if (cur.running) begin
      nxt.elapsed = elapsed_inc;
      nxt.pos     = pos_upd;
      nxt.running = tick_pick.move;
      if (tick_pick.move) nxt.dir = tick_pick.dir;
    end
  end

endmodule

// ===== rtl/three_position_actuator_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_position_actuator_control
// Valve control that moves an actuator to one of five estimated positions.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low: a goal set (op 0) or a
// travel tick (op 1), and returns one result per item with the estimated
// position, the valve command and the busy flag. Sustained rate is one item
// every cycle while out_stall is low. Each item passes through the input
// register, then the result register, with the per-item update done in one
// pass of logic between them. in_stall rises only while both registers are
// full and out_stall is high. travel_ticks may be written only while idle; a
// value of 0 behaves as 1.
// ----------------------------------------------------------------------------
module three_position_actuator_control (
  input  logic                             clk,
  input  logic                             rst,
  // config
  input  logic                             cfg_we,
  input  logic [tpac_pkg::TICK_W-1:0]      cfg_wdata,
  // item input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [tpac_pkg::POS_W-1:0]       new_goal,
  input  logic                             center_line,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tpac_pkg::POS_W-1:0]       position_now,
  output logic [tpac_pkg::DIR_W-1:0]       valve_drive,
  output logic                             busy_res
);

  // Config register.
  logic [tpac_pkg::TICK_W-1:0] travel_ticks;

  // Input register.
  logic                        s1_valid;
  logic                        s1_op;
  logic [tpac_pkg::POS_W-1:0]  s1_goal;
  logic                        s1_center;

  // Actuator state.
  tpac_pkg::state_t            st;
  tpac_pkg::state_t            st_next;

  logic                        advance;
  logic                        in_take;

  // Stage 1 moves on when the result register is empty or being drained.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_ticks <= tpac_pkg::TRAVEL_TICKS_RESET;
    end else if (cfg_we) begin
      travel_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op     <= op;
      s1_goal   <= new_goal;
      s1_center <= center_line;
    end
  end

  tpac_step u_step (
    .cur          (st),
    .travel_ticks (travel_ticks),
    .op           (s1_op),
    .new_goal     (s1_goal),
    .center_line  (s1_center),
    .nxt          (st_next)
  );

  // State commits in the same cycle the item lands in the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pos     <= tpac_pkg::POS_UNKNOWN;
      st.target  <= tpac_pkg::POS_UNKNOWN;
      st.dir     <= tpac_pkg::DIR_OFF;
      st.running <= 1'b0;
      st.elapsed <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Valve is driven only while running.
  always_ff @(posedge clk) begin
    if (advance) begin
      position_now <= st_next.pos;
      valve_drive  <= st_next.running ? st_next.dir : tpac_pkg::DIR_OFF;
      busy_res     <= st_next.running;
    end
  end

  // A shown result with the block stopped never drives the valve.
  a_valve_off_when_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> (valve_drive == tpac_pkg::DIR_OFF))
    else $error("valve driven while not busy");

  // Running implies a known goal that is not yet reached.
  a_running_goal: assert property (@(posedge clk) disable iff (rst)
    st.running |-> ((st.target != tpac_pkg::POS_UNKNOWN) && (st.pos != st.target)))
    else $error("running with goal unknown or reached");

  // A goal item restarts the travel count.
  a_goal_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_op == tpac_pkg::OP_GOAL)) |=> (st.elapsed == '0))
    else $error("tick count not cleared by goal item");

  // Busy on the output mirrors the committed running flag.
  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (busy_res == st.running))
    else $error("busy output disagrees with state");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-position actuator valve control.
// ----------------------------------------------------------------------------
// Every accepted item (goal set or travel tick) is run through a local
// position/valve estimator. The expected result is queued and then compared
// field by field against each accepted result. Coverage comes from a short
// directed walk through the positions, runs at the shortest and the largest
// travel settings, and random goal/tick sequences under several travel
// settings. Random gaps on the item side and random stalls on the result
// side run throughout, with some stretches that have none.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD = 2;
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES = 10;    // idle margin before the final check

  typedef struct packed {
    logic [tpac_pkg::POS_W-1:0] pos;
    logic [tpac_pkg::DIR_W-1:0] valve;
    logic                       busy;
  } actuator_result_t;

  // --------------------------------------------------------------------------
  // Position estimator and result queue
  // --------------------------------------------------------------------------
  class actuator_scoreboard;
    logic [tpac_pkg::TICK_W-1:0] travel;
    logic [tpac_pkg::POS_W-1:0]  pos;
    logic [tpac_pkg::POS_W-1:0]  goal;
    logic [tpac_pkg::DIR_W-1:0]  dir;
    logic                        moving;
    logic [tpac_pkg::TICK_W-1:0] ticks;
    actuator_result_t            expected_q[$];
    int                          errors;

    function new();
      travel = tpac_pkg::TRAVEL_TICKS_RESET;
      pos    = tpac_pkg::POS_UNKNOWN;
      goal   = tpac_pkg::POS_UNKNOWN;
      dir    = tpac_pkg::DIR_OFF;
      moving = 1'b0;
      ticks  = '0;
      errors = 0;
    endfunction

    function void set_travel(logic [tpac_pkg::TICK_W-1:0] value);
      travel = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Sets dir toward the goal; 0 when there already or the goal is unknown.
    function bit steer();
      if (pos == goal || goal == tpac_pkg::POS_UNKNOWN) return 1'b0;
      case (goal)
        tpac_pkg::POS_RETRACTED: dir = tpac_pkg::DIR_REV;
        tpac_pkg::POS_PART_RET:
          dir = (pos == tpac_pkg::POS_RETRACTED) ? tpac_pkg::DIR_FWD : tpac_pkg::DIR_REV;
        tpac_pkg::POS_CENTER:
          dir = (pos == tpac_pkg::POS_RETRACTED || pos == tpac_pkg::POS_PART_RET)
                ? tpac_pkg::DIR_FWD : tpac_pkg::DIR_REV;
        tpac_pkg::POS_PART_EXT:
          dir = (pos == tpac_pkg::POS_EXTENDED) ? tpac_pkg::DIR_REV : tpac_pkg::DIR_FWD;
        tpac_pkg::POS_EXTENDED:  dir = tpac_pkg::DIR_FWD;
        default:                 dir = tpac_pkg::DIR_OFF;
      endcase
      return 1'b1;
    endfunction

    function void note_input(logic op_in, logic [tpac_pkg::POS_W-1:0] goal_in,
                             logic center_in);
      actuator_result_t r;
      bit timed_out;
      if (op_in == tpac_pkg::OP_GOAL) begin
        goal   = goal_in;
        ticks  = '0;
        moving = steer();
      end else if (moving) begin
        if (ticks != tpac_pkg::TICK_MAX) ticks = ticks + 1'b1;
        timed_out = (ticks >= travel);
        if (!center_in) begin
          pos = tpac_pkg::POS_CENTER;
        end else if (dir == tpac_pkg::DIR_FWD) begin
          if (pos == tpac_pkg::POS_RETRACTED)   pos = tpac_pkg::POS_PART_RET;
          else if (pos == tpac_pkg::POS_CENTER) pos = tpac_pkg::POS_PART_EXT;
          else if (timed_out)                   pos = tpac_pkg::POS_EXTENDED;
        end else if (dir == tpac_pkg::DIR_REV) begin
          if (pos == tpac_pkg::POS_EXTENDED)    pos = tpac_pkg::POS_PART_EXT;
          else if (pos == tpac_pkg::POS_CENTER) pos = tpac_pkg::POS_PART_RET;
          else if (timed_out)                   pos = tpac_pkg::POS_RETRACTED;
        end
        if (!steer()) moving = 1'b0;
      end
      r.pos   = pos;
      r.valve = moving ? dir : tpac_pkg::DIR_OFF;
      r.busy  = moving;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_result(logic [tpac_pkg::POS_W-1:0] p, logic [tpac_pkg::DIR_W-1:0] v,
                      logic b);
      actuator_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (p !== want.pos)
        report($sformatf("position_now got %0d expected %0d", p, want.pos));
      if (v !== want.valve)
        report($sformatf("valve_drive got %0d expected %0d", v, want.valve));
      if (b !== want.busy)
        report($sformatf("busy_res got %0d expected %0d", b, want.busy));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; all inputs start at known values
  // --------------------------------------------------------------------------
  logic                        clk;
  logic                        rst         = 1'b1;
  logic                        cfg_we      = 1'b0;
  logic [tpac_pkg::TICK_W-1:0] cfg_wdata   = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        op          = tpac_pkg::OP_GOAL;
  logic [tpac_pkg::POS_W-1:0]  new_goal    = tpac_pkg::POS_UNKNOWN;
  logic                        center_line = 1'b1;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [tpac_pkg::POS_W-1:0]  position_now;
  logic [tpac_pkg::DIR_W-1:0]  valve_drive;
  logic                        busy_res;

  actuator_scoreboard sb;
  bit                 calm         = 1'b0;  // no gaps, no stalls while set
  int                 stall_left   = 0;
  int unsigned        quiet_cycles = 0;

  three_position_actuator_control uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .new_goal     (new_goal),
    .center_line  (center_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position_now (position_now),
    .valve_drive  (valve_drive),
    .busy_res     (busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Goals are weighted toward real positions; unknown and the unused codes
  // still show up regularly.
  function automatic logic [tpac_pkg::POS_W-1:0] pick_goal();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return tpac_pkg::POS_W'($urandom_range(6, 7));
    if (r < 14) return tpac_pkg::POS_UNKNOWN;
    return tpac_pkg::POS_W'($urandom_range(tpac_pkg::POS_RETRACTED,
                                           tpac_pkg::POS_EXTENDED));
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: both handshakes are sampled at the rising edge, before any
  // nonblocking update of that edge lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(op, new_goal, center_line);
    if (!rst && out_valid && !out_stall) sb.check_result(position_now, valve_drive, busy_res);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Result-side back-pressure: alternating run and stall bursts. A stall
  // burst always ends in a run burst, so results keep draining.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_stall && $urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_left <= gap_length();
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end
  end

  // Watchdog: a stuck handshake ends the run.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Item driver. Called at a rising edge; returns at the edge that accepted
  // the item, so the next call can present its item without a bubble.
  // --------------------------------------------------------------------------
  task automatic send_item(logic o, logic [tpac_pkg::POS_W-1:0] g, logic c);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 99) < 55) ? 0 : gap_length());
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    new_goal    <= g;
    center_line <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off new items until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Register writes only happen with the block empty; every item yields a
  // result, so an empty queue means nothing is in flight.
  task automatic write_travel(logic [tpac_pkg::TICK_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_travel(value);
  endtask

  // Mostly a goal followed by a run of ticks with the sensor mostly off
  // center; the rest is loose items of any kind.
  task automatic random_phase(int items);
    int sent;
    int r;
    int n;
    int max_run;
    sent    = 0;
    max_run = (sb.travel * 2 + 4 > 24) ? 24 : int'(sb.travel) * 2 + 4;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 2) wait_drained();
      if (r < 85) begin
        n = $urandom_range(1, max_run);
        send_item(tpac_pkg::OP_GOAL, pick_goal(), 1'($urandom_range(0, 1)));
        repeat (n)
          send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_W'($urandom_range(0, 7)),
                    ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1);
        sent += n + 1;
      end else begin
        send_item(1'($urandom_range(0, 1)), tpac_pkg::POS_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed walk at the reset travel setting; position starts unknown.
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);   // tick while stopped
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b0);   // even at center
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_UNKNOWN, 1'b1);   // unknown goal stops
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_CENTER, 1'b1);    // reverse toward center
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);   // no timeout yet
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b0);   // sensor says center
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_CENTER, 1'b1);    // already there
    send_item(tpac_pkg::OP_GOAL, 3'd6, 1'b1);                    // unused code: busy
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_GOAL, 3'd7, 1'b0);                    // sensor ignored
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b0);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_PART_EXT, 1'b1);  // leaving center fwd
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_PART_RET, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b0);   // passes center
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);   // leaves center rev
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_EXTENDED, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_RETRACTED, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);

    // Shortest travel: end positions are reached on the first timed tick.
    write_travel(10'd1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);   // reaches retracted
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_EXTENDED, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_RETRACTED, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);

    // Back-to-back stretch with no gaps or stalls.
    calm = 1'b1;
    random_phase(120);

    // Longest travel: start from retracted, the end is never timed out, then
    // park on an unused goal for a while.
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_RETRACTED, 1'b1);
    repeat (3) send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    write_travel(10'd1023);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_EXTENDED, 1'b1);
    repeat (40) send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_GOAL, 3'd7, 1'b1);
    repeat (40) send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b0);
    send_item(tpac_pkg::OP_GOAL, tpac_pkg::POS_EXTENDED, 1'b1);  // count restarts
    send_item(tpac_pkg::OP_TICK, tpac_pkg::POS_UNKNOWN, 1'b1);
    calm = 1'b0;
    random_phase(120);

    // Zero travel behaves like one.
    write_travel(10'd0);
    random_phase(120);

    write_travel(tpac_pkg::TICK_W'($urandom_range(2, 12)));
    random_phase(160);

    write_travel(tpac_pkg::TRAVEL_TICKS_RESET);
    random_phase(120);

    write_travel(tpac_pkg::TICK_W'($urandom_range(1, 1023)));
    random_phase(60);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
